/* rtl/core/art_pkg.sv */
// Shared types and constants for the acknowledgement retransmission table.
// Depends on nothing; the controller, datapath and top level import it.
`default_nettype none
package art_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [15:0] RETRY_RESET = 16'd1000;

  typedef enum logic [2:0] {
    K_SEND      = 3'd0,
    K_ACK       = 3'd1,
    K_DROP_PEER = 3'd2,
    K_DROP_HDR  = 3'd3,
    K_RETRY     = 3'd4,
    K_BIND      = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    RK_TRANSMIT = 2'd0,
    RK_ACKED    = 2'd1,
    RK_FULL     = 2'd2,
    RK_DONE     = 2'd3
  } rkind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FULL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             load;
    logic             scan_en;
    logic [IDX_W-1:0] idx;
    logic             emit_full;
    logic             emit_done;
  } cmd_t;

  typedef struct packed {
    logic is_send;
    logic free_hit;
  } status_t;

endpackage
`default_nettype wire

/* rtl/core/art_ctrl.sv */
// Controller state machine: walks the slot index and sequences result beats.
// Depends on art_pkg.
`default_nettype none
module art_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  output logic             busy,
  input  art_pkg::status_t status,
  output art_pkg::cmd_t    cmd
);
  import art_pkg::*;

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    cmd.load      = 1'b0;
    cmd.scan_en   = 1'b0;
    cmd.idx       = idx;
    cmd.emit_full = 1'b0;
    cmd.emit_done = 1'b0;
    busy          = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          idx_next   = '0;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.is_send && status.free_hit) begin
          state_next = ST_DONE;
        end else if (idx == IDX_W'(TABLE_DEPTH - 1)) begin
          state_next = status.is_send ? ST_FULL : ST_DONE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_FULL: begin
        cmd.emit_full = 1'b1;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        cmd.emit_done = 1'b1;
        state_next    = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted beat did not raise busy");
  a_full_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FULL) |=> (state == ST_DONE)) else $error("full not followed by done");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |=> (state == ST_IDLE)) else $error("done not followed by idle");
`endif
endmodule
`default_nettype wire

/* rtl/core/art_datapath.sv */
// Datapath: request latch, slot table, retry register and output register.
// Depends on art_pkg.
`default_nettype none
module art_datapath (
  input  wire               clk,
  input  wire               rst,
  input  art_pkg::cmd_t     cmd,
  output art_pkg::status_t  status,
  input  wire               retry_interval_we,
  input  wire  [15:0]       retry_interval,
  input  wire  [2:0]        kind,
  input  wire               bind_by_header,
  input  wire  [31:0]       peer_ip,
  input  wire  [15:0]       peer_port,
  input  wire  [31:0]       ack_id,
  input  wire  [15:0]       header,
  input  wire  [15:0]       packet_handle,
  input  wire  [7:0]        callback_tag,
  input  wire  [31:0]       now_time,
  output logic              result_strobe,
  output logic [1:0]        result_kind,
  output logic [31:0]       peer_ip_res,
  output logic [15:0]       peer_port_res,
  output logic [31:0]       ack_id_res,
  output logic [15:0]       packet_handle_res,
  output logic [7:0]        callback_tag_res,
  output logic              last
);
  import art_pkg::*;

  logic [15:0] interval;
  logic [2:0]  r_kind;
  logic        r_by_hdr;
  logic [31:0] r_ip, r_ack, r_now;
  logic [15:0] r_port, r_hdr, r_handle;
  logic [7:0]  r_tag;

  logic [TABLE_DEPTH-1:0] valid;
  logic [31:0] s_ip   [TABLE_DEPTH];
  logic [15:0] s_port [TABLE_DEPTH];
  logic [31:0] s_ack  [TABLE_DEPTH];
  logic [15:0] s_hdr  [TABLE_DEPTH];
  logic [15:0] s_hnd  [TABLE_DEPTH];
  logic [7:0]  s_tag  [TABLE_DEPTH];
  logic [31:0] s_last [TABLE_DEPTH];

  logic        v, peer_eq, age_hit;
  logic        do_send, do_ack, do_drop, do_retry, do_bind;
  logic [31:0] age;

  always_comb begin
    v        = valid[cmd.idx];
    peer_eq  = (s_ip[cmd.idx] == r_ip) && (s_port[cmd.idx] == r_port);
    age      = r_now - s_last[cmd.idx];
    age_hit  = age > {16'd0, interval};
    do_send  = cmd.scan_en && (r_kind == K_SEND) && !v;
    do_ack   = cmd.scan_en && (r_kind == K_ACK) && v && peer_eq &&
               (s_ack[cmd.idx] == r_ack);
    do_drop  = cmd.scan_en && v && peer_eq && ((r_kind == K_DROP_PEER) ||
               ((r_kind == K_DROP_HDR) && (s_hdr[cmd.idx] == r_hdr)));
    do_retry = cmd.scan_en && (r_kind == K_RETRY) && v && age_hit;
    do_bind  = cmd.scan_en && (r_kind == K_BIND) && v &&
               (r_by_hdr ? (s_hdr[cmd.idx] == r_hdr) : (s_ack[cmd.idx] == r_ack));
    status.is_send  = (r_kind == K_SEND);
    status.free_hit = !v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= RETRY_RESET;
    end else if (retry_interval_we) begin
      interval <= retry_interval;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_kind   <= kind;
      r_by_hdr <= bind_by_header;
      r_ip     <= peer_ip;
      r_port   <= peer_port;
      r_ack    <= ack_id;
      r_hdr    <= header;
      r_handle <= packet_handle;
      r_tag    <= callback_tag;
      r_now    <= now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (do_send) begin
      valid[cmd.idx] <= 1'b1;
    end else if (do_ack || do_drop) begin
      valid[cmd.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_send) begin
      s_ip[cmd.idx]   <= r_ip;
      s_port[cmd.idx] <= r_port;
      s_ack[cmd.idx]  <= r_ack;
      s_hdr[cmd.idx]  <= r_hdr;
      s_hnd[cmd.idx]  <= r_handle;
    end
    if (do_send) begin
      s_tag[cmd.idx] <= 8'd0;
    end else if (do_bind) begin
      s_tag[cmd.idx] <= r_tag;
    end
    if (do_send || do_retry) begin
      s_last[cmd.idx] <= r_now;
    end
  end

  // Output register: one beat per cycle at most.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= do_send || do_ack || do_retry || cmd.emit_full || cmd.emit_done;
    end
  end

  always_ff @(posedge clk) begin
    last <= cmd.emit_done;
    if (do_send || cmd.emit_full) begin
      result_kind       <= do_send ? RK_TRANSMIT : RK_FULL;
      peer_ip_res       <= r_ip;
      peer_port_res     <= r_port;
      ack_id_res        <= r_ack;
      packet_handle_res <= r_handle;
      callback_tag_res  <= 8'd0;
    end else if (do_ack || do_retry) begin
      result_kind       <= do_ack ? RK_ACKED : RK_TRANSMIT;
      peer_ip_res       <= s_ip[cmd.idx];
      peer_port_res     <= s_port[cmd.idx];
      ack_id_res        <= s_ack[cmd.idx];
      packet_handle_res <= s_hnd[cmd.idx];
      callback_tag_res  <= do_ack ? s_tag[cmd.idx] : 8'd0;
    end else begin
      result_kind       <= RK_DONE;
      peer_ip_res       <= 32'd0;
      peer_port_res     <= 16'd0;
      ack_id_res        <= 32'd0;
      packet_handle_res <= 16'd0;
      callback_tag_res  <= 8'd0;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/ack_retransmit_table_unit.sv */
// Busy stays high from the accepting edge through the done state; one slot a cycle.
// A send stops at the first free slot (a full table adds a rejection beat); other kinds walk
// every slot, and a done beat always closes the item.
// Results leave a registered output in the cycle after the slot is examined; start is taken again
// in the idle cycle after the done state, so a new item is accepted only once the last is done.
// The receiver cannot stall; reset (rst, synchronous) empties the table, retry interval 1000.
`default_nettype none
module ack_retransmit_table_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire         retry_interval_we,
  input  wire  [15:0] retry_interval,
  input  wire  [2:0]  kind,
  input  wire         bind_by_header,
  input  wire  [31:0] peer_ip,
  input  wire  [15:0] peer_port,
  input  wire  [31:0] ack_id,
  input  wire  [15:0] header,
  input  wire  [15:0] packet_handle,
  input  wire  [7:0]  callback_tag,
  input  wire  [31:0] now_time,
  output logic        result_strobe,
  output logic [1:0]  result_kind,
  output logic [31:0] peer_ip_res,
  output logic [15:0] peer_port_res,
  output logic [31:0] ack_id_res,
  output logic [15:0] packet_handle_res,
  output logic [7:0]  callback_tag_res,
  output logic        last
);
  import art_pkg::*;

  // The controller and datapath exchange only a command word and a status word.
  cmd_t    cmd;
  status_t status;

  art_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  art_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .retry_interval_we (retry_interval_we),
    .retry_interval    (retry_interval),
    .kind              (kind),
    .bind_by_header    (bind_by_header),
    .peer_ip           (peer_ip),
    .peer_port         (peer_port),
    .ack_id            (ack_id),
    .header            (header),
    .packet_handle     (packet_handle),
    .callback_tag      (callback_tag),
    .now_time          (now_time),
    .result_strobe     (result_strobe),
    .result_kind       (result_kind),
    .peer_ip_res       (peer_ip_res),
    .peer_port_res     (peer_port_res),
    .ack_id_res        (ack_id_res),
    .packet_handle_res (packet_handle_res),
    .callback_tag_res  (callback_tag_res),
    .last              (last)
  );
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the acknowledgement retransmission table.
// Depends on art_pkg and ack_retransmit_table_unit, and through it on art_ctrl and art_datapath.
`default_nettype none
module tb_top;
  import art_pkg::*;

  // The work queue carries input items, writes of the retry interval, and
  // quiet points at which the sender waits for every expected result.
  typedef enum int {OP_ITEM, OP_CFG, OP_QUIET} op_t;

  typedef struct {
    op_t         op;
    int          idle_pct;
    logic [2:0]  kind;
    logic        by_hdr;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] ack;
    logic [15:0] hdr;
    logic [15:0] handle;
    logic [7:0]  tag;
    logic [31:0] now;
    logic [15:0] interval;
  } work_t;

  typedef struct {
    rkind_t      rk;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] ack;
    logic [15:0] handle;
    logic [7:0]  tag;
    logic        last;
  } beat_t;

  localparam int DRAIN_CYCLES = TABLE_DEPTH + 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        retry_interval_we = 1'b0;
  logic [15:0] retry_interval = 16'd0;
  logic [2:0]  kind = 3'd0;
  logic        bind_by_header = 1'b0;
  logic [31:0] peer_ip = 32'd0;
  logic [15:0] peer_port = 16'd0;
  logic [31:0] ack_id = 32'd0;
  logic [15:0] header = 16'd0;
  logic [15:0] packet_handle = 16'd0;
  logic [7:0]  callback_tag = 8'd0;
  logic [31:0] now_time = 32'd0;
  logic        result_strobe;
  logic [1:0]  result_kind;
  logic [31:0] peer_ip_res;
  logic [15:0] peer_port_res;
  logic [31:0] ack_id_res;
  logic [15:0] packet_handle_res;
  logic [7:0]  callback_tag_res;
  logic        last;

  ack_retransmit_table_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .retry_interval_we(retry_interval_we), .retry_interval(retry_interval),
    .kind(kind), .bind_by_header(bind_by_header), .peer_ip(peer_ip),
    .peer_port(peer_port), .ack_id(ack_id), .header(header),
    .packet_handle(packet_handle), .callback_tag(callback_tag),
    .now_time(now_time), .result_strobe(result_strobe),
    .result_kind(result_kind), .peer_ip_res(peer_ip_res),
    .peer_port_res(peer_port_res), .ack_id_res(ack_id_res),
    .packet_handle_res(packet_handle_res), .callback_tag_res(callback_tag_res),
    .last(last)
  );

  // The testbench's own copy of the table and of the retry interval.
  logic        tbl_valid [TABLE_DEPTH];
  logic [31:0] tbl_ip [TABLE_DEPTH];
  logic [15:0] tbl_port [TABLE_DEPTH];
  logic [31:0] tbl_ack [TABLE_DEPTH];
  logic [15:0] tbl_hdr [TABLE_DEPTH];
  logic [15:0] tbl_handle [TABLE_DEPTH];
  logic [7:0]  tbl_tag [TABLE_DEPTH];
  logic [31:0] tbl_sent [TABLE_DEPTH];
  logic [15:0] interval_now = RETRY_RESET;

  work_t work_q[$];
  beat_t pending_beats[$];
  work_t cur;
  int    errors = 0;
  int    quiet = 0;

  // Gen-side bookkeeping: the tick count advances as items are generated.
  logic [31:0] gen_now = 32'hFFFF_F000;
  int          gen_idle = 24;

  initial begin
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      tbl_valid[s] = 1'b0;
    end
  end

  // Appends one expected beat at the tail of the expectation queue.
  task automatic queue_beat(beat_t b);
    pending_beats = {pending_beats, b};
  endtask

  // Appends one entry at the tail of the work queue.
  task automatic queue_work(work_t w);
    work_q = {work_q, w};
  endtask

  function automatic beat_t slot_beat(rkind_t rk, int s, logic [7:0] tag);
    beat_t b;
    b.rk = rk;
    b.ip = tbl_ip[s];
    b.port = tbl_port[s];
    b.ack = tbl_ack[s];
    b.handle = tbl_handle[s];
    b.tag = tag;
    b.last = 1'b0;
    return b;
  endfunction

  // Works out the beats that one accepted item causes and updates the
  // table copy exactly as the block must.
  task automatic predict_table_beats(work_t w);
    int    free_slot;
    beat_t b;
    free_slot = -1;
    case (w.kind)
      K_SEND: begin
        for (int s = TABLE_DEPTH - 1; s >= 0; s--) begin
          if (!tbl_valid[s]) free_slot = s;
        end
        if (free_slot < 0) begin
          b.rk = RK_FULL; b.ip = w.ip; b.port = w.port; b.ack = w.ack;
          b.handle = w.handle; b.tag = 8'd0; b.last = 1'b0;
          queue_beat(b);
        end else begin
          tbl_valid[free_slot] = 1'b1;
          tbl_ip[free_slot] = w.ip;
          tbl_port[free_slot] = w.port;
          tbl_ack[free_slot] = w.ack;
          tbl_hdr[free_slot] = w.hdr;
          tbl_handle[free_slot] = w.handle;
          tbl_tag[free_slot] = 8'd0;
          tbl_sent[free_slot] = w.now;
          queue_beat(slot_beat(RK_TRANSMIT, free_slot, 8'd0));
        end
      end
      K_ACK: begin
        for (int s = 0; s < TABLE_DEPTH; s++) begin
          if (tbl_valid[s] && tbl_ack[s] == w.ack && tbl_ip[s] == w.ip &&
              tbl_port[s] == w.port) begin
            queue_beat(slot_beat(RK_ACKED, s, tbl_tag[s]));
            tbl_valid[s] = 1'b0;
          end
        end
      end
      K_DROP_PEER, K_DROP_HDR: begin
        for (int s = 0; s < TABLE_DEPTH; s++) begin
          if (tbl_valid[s] && tbl_ip[s] == w.ip && tbl_port[s] == w.port &&
              (w.kind == K_DROP_PEER || tbl_hdr[s] == w.hdr))
            tbl_valid[s] = 1'b0;
        end
      end
      K_RETRY: begin
        // The age wraps modulo 2^32, so a 32-bit difference is exact.
        for (int s = 0; s < TABLE_DEPTH; s++) begin
          if (tbl_valid[s] && (w.now - tbl_sent[s]) > {16'd0, interval_now}) begin
            tbl_sent[s] = w.now;
            queue_beat(slot_beat(RK_TRANSMIT, s, 8'd0));
          end
        end
      end
      K_BIND: begin
        for (int s = 0; s < TABLE_DEPTH; s++) begin
          if (tbl_valid[s] && (w.by_hdr ? tbl_hdr[s] == w.hdr : tbl_ack[s] == w.ack))
            tbl_tag[s] = w.tag;
        end
      end
      default: ;
    endcase
    b.rk = RK_DONE; b.ip = '0; b.port = '0; b.ack = '0;
    b.handle = '0; b.tag = '0; b.last = 1'b1;
    queue_beat(b);
  endtask

  task automatic add_item(logic [2:0] k, logic bh, logic [31:0] ip, logic [15:0] port,
                          logic [31:0] ack, logic [15:0] hdr, logic [15:0] handle,
                          logic [7:0] tag, logic [31:0] t);
    work_t w;
    w.op = OP_ITEM; w.idle_pct = gen_idle; w.kind = k; w.by_hdr = bh;
    w.ip = ip; w.port = port; w.ack = ack; w.hdr = hdr; w.handle = handle;
    w.tag = tag; w.now = t; w.interval = '0;
    queue_work(w);
  endtask

  task automatic add_ctrl(op_t op, logic [15:0] val);
    work_t w;
    w.op = op; w.idle_pct = 0; w.kind = '0; w.by_hdr = 1'b0;
    w.ip = '0; w.port = '0; w.ack = '0; w.hdr = '0; w.handle = '0;
    w.tag = '0; w.now = '0;
    w.interval = val;
    queue_work(w);
  endtask

  // Random item drawn mostly from small pools of peers, ack ids and headers
  // so that acks, drops and binds actually find entries.
  task automatic add_random_item();
    logic [31:0] ips [3];
    logic [15:0] ports [3];
    logic [2:0]  k;
    int          r;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] ack;
    logic [15:0] hdr;
    ips = '{32'h0A00_0001, 32'hC0A8_0001, 32'hFFFF_FFFF};
    ports = '{16'd0, 16'd8080, 16'hFFFF};
    r = $urandom_range(99);
    if (r < 38) k = K_SEND;
    else if (r < 58) k = K_ACK;
    else if (r < 66) k = K_DROP_PEER;
    else if (r < 72) k = K_DROP_HDR;
    else if (r < 85) k = K_RETRY;
    else if (r < 96) k = K_BIND;
    else k = 3'($urandom_range(6, 7));
    ip = ips[$urandom_range(2)];
    port = ports[$urandom_range(2)];
    ack = 32'($urandom_range(5));
    hdr = 16'($urandom_range(3));
    // A minority of items carry fully random fields as noise.
    if ($urandom_range(9) == 0) begin
      ip = $urandom; port = 16'($urandom); ack = $urandom; hdr = 16'($urandom);
    end
    // Time mostly creeps forward, sometimes jumps far, and wraps.
    if ($urandom_range(19) == 0) gen_now = gen_now + $urandom;
    else gen_now = gen_now + 32'($urandom_range(700));
    add_item(k, 1'($urandom), ip, port, ack, hdr, 16'($urandom), 8'($urandom), gen_now);
  endtask

  initial begin
    // Directed part: field extremes, duplicates and every kind.
    add_item(K_SEND, 1'b0, 32'h0, 16'h0, 32'h0, 16'h0, 16'h0, 8'h00, 32'h0);
    add_item(K_SEND, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
             16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    add_item(K_SEND, 1'b0, 32'h0, 16'h0, 32'h0, 16'h5, 16'h1234, 8'h00, 32'h10);
    add_item(K_BIND, 1'b0, 32'h0, 16'h0, 32'h0, 16'h0, 16'h0, 8'hA5, 32'h20);
    add_item(K_BIND, 1'b1, 32'h0, 16'h0, 32'h1, 16'hFFFF, 16'h0, 8'hFF, 32'h21);
    add_item(K_ACK, 1'b0, 32'h0, 16'h0, 32'h0, 16'h0, 16'h0, 8'h00, 32'h30);
    add_item(K_RETRY, 1'b0, 32'h0, 16'h0, 32'h0, 16'h0, 16'h0, 8'h00, 32'h0000_0400);
    add_item(K_RETRY, 1'b0, 32'h0, 16'h0, 32'h0, 16'h0, 16'h0, 8'h00, 32'h0000_0401);
    add_item(K_DROP_HDR, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 16'h0, 8'h00, 32'h0);
    add_item(K_DROP_PEER, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 16'h0, 8'h0, 32'h0);
    add_item(3'd6, 1'b1, 32'h0, 16'h0, 32'h0, 16'h0, 16'h0, 8'h00, 32'h0);
    add_item(3'd7, 1'b1, 32'h0, 16'h0, 32'h0, 16'h0, 16'h0, 8'h00, 32'h0);
    for (int i = 0; i < 13; i++) begin
      add_item(K_SEND, 1'b0, 32'h0A00_0001, 16'd8080, 32'(i), 16'(i), 16'(i), 8'h0,
               32'h100);
    end
    add_ctrl(OP_QUIET, 16'd0);
    gen_now = 32'h200;
    // Three phases of random items, each with its own retry interval and sender idling.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin gen_idle = 24; add_ctrl(OP_CFG, 16'd1); end
        1: begin gen_idle = 86; add_ctrl(OP_CFG, 16'hFFFF); end
        default: begin gen_idle = 0; add_ctrl(OP_CFG, 16'($urandom_range(100, 2000))); end
      endcase
      for (int i = 0; i < 136; i++) begin
        add_random_item();
        if (i == 60) add_ctrl(OP_QUIET, 16'd0);
        if (i == 90) add_ctrl(OP_CFG, (ph == 0) ? 16'd0 : 16'($urandom_range(1, 800)));
      end
    end
  end

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: presents items, holds an item until it is taken, writes the
  // interval only once the block has gone quiet, and ends the run.
  always @(posedge clk) begin : drive_items
    logic taken;
    logic we_next;
    if (rst) begin
      start <= 1'b0;
      retry_interval_we <= 1'b0;
      quiet = 0;
    end else begin
      taken = start && !busy;
      we_next = 1'b0;
      if (taken) predict_table_beats(cur);
      // Quiet counts cycles with nothing outstanding, so a write lands only
      // after any trailing beats of the last item have left the block.
      if (pending_beats.size() == 0 && !busy && !start) quiet++;
      else quiet = 0;
      if (start && !taken) begin
        // The beat is still on offer; keep start and the fields as they are.
      end else if (work_q.size() == 0) begin
        start <= 1'b0;
        if (quiet >= DRAIN_CYCLES + 20) begin
          if (errors == 0) $display("end of test: clean");
          else $display("end of test: mismatches");
          $finish;
        end
      end else if (work_q[0].op == OP_ITEM) begin
        if ($urandom_range(99) < work_q[0].idle_pct) begin
          start <= 1'b0;
        end else begin
          cur = work_q.pop_front();
          kind <= cur.kind;
          bind_by_header <= cur.by_hdr;
          peer_ip <= cur.ip;
          peer_port <= cur.port;
          ack_id <= cur.ack;
          header <= cur.hdr;
          packet_handle <= cur.handle;
          callback_tag <= cur.tag;
          now_time <= cur.now;
          start <= 1'b1;
        end
      end else begin
        start <= 1'b0;
        if (quiet >= DRAIN_CYCLES) begin
          if (work_q[0].op == OP_CFG) begin
            we_next = 1'b1;
            retry_interval <= work_q[0].interval;
            interval_now = work_q[0].interval;
          end
          void'(work_q.pop_front());
          quiet = 0;
        end
      end
      retry_interval_we <= we_next;
    end
  end

  // Monitor: every strobed beat is checked against the oldest expectation.
  always @(posedge clk) begin : check_beats
    beat_t e;
    if (!rst && result_strobe) begin
      if (pending_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat kind %0d ip %h", $time, result_kind, peer_ip_res);
      end else begin
        e = pending_beats.pop_front();
        if (result_kind !== e.rk) begin
          errors++;
          $display("%0t: result_kind expected %0d actual %0d", $time, e.rk, result_kind);
        end
        if (peer_ip_res !== e.ip) begin
          errors++;
          $display("%0t: peer_ip_res expected %h actual %h", $time, e.ip, peer_ip_res);
        end
        if (peer_port_res !== e.port) begin
          errors++;
          $display("%0t: peer_port_res expected %h actual %h", $time, e.port, peer_port_res);
        end
        if (ack_id_res !== e.ack) begin
          errors++;
          $display("%0t: ack_id_res expected %h actual %h", $time, e.ack, ack_id_res);
        end
        if (packet_handle_res !== e.handle) begin
          errors++;
          $display("%0t: packet_handle_res expected %h actual %h", $time, e.handle,
                   packet_handle_res);
        end
        if (callback_tag_res !== e.tag) begin
          errors++;
          $display("%0t: callback_tag_res expected %h actual %h", $time, e.tag,
                   callback_tag_res);
        end
        if (last !== e.last) begin
          errors++;
          $display("%0t: last expected %b actual %b", $time, e.last, last);
        end
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
